>>> sv/gps_pkg.sv
package gps_pkg;

    localparam logic [1:0] ACT_CONFIGURE = 2'd0;
    localparam logic [1:0] ACT_POLL      = 2'd1;
    localparam logic [1:0] ACT_BYTE      = 2'd2;

    localparam logic [1:0] STAT_IDLE       = 2'd0;
    localparam logic [1:0] STAT_BUSY       = 2'd1;
    localparam logic [1:0] STAT_CONFIGURED = 2'd2;
    localparam logic [1:0] STAT_FAILED     = 2'd3;

    localparam logic [3:0] RETRY_LIMIT_RESET = 4'd10;
    localparam logic [3:0] ATTEMPT_MAX       = 4'd15;
    localparam logic [7:0] ID_MASK           = 8'hF0;
    localparam logic [7:0] ID_ANALOG         = 8'h70;

    // frame table rows
    localparam logic [1:0] FRM_ENTER  = 2'd0;
    localparam logic [1:0] FRM_ANALOG = 2'd1;
    localparam logic [1:0] FRM_EXIT   = 2'd2;
    localparam logic [1:0] FRM_POLL   = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_ENTER     = 3'd1,
        PH_ANALOG    = 3'd2,
        PH_EXIT      = 3'd3,
        PH_POLL_CFG  = 3'd4,
        PH_POLL_ONLY = 3'd5
    } phase_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] rx_byte;
    } gps_cmd_t;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        select_active;
        logic        frame_end;
        logic [15:0] buttons_held;
        logic [15:0] newly_pressed;
        logic [15:0] newly_released;
        logic [7:0]  right_x;
        logic [7:0]  right_y;
        logic [7:0]  left_x;
        logic [7:0]  left_y;
        logic [7:0]  device_id;
        logic [1:0]  status;
    } gps_res_t;

    function automatic logic [1:0] frame_row(phase_t ph);
        logic [1:0] row;
        unique case (ph)
            PH_ENTER:  row = FRM_ENTER;
            PH_ANALOG: row = FRM_ANALOG;
            PH_EXIT:   row = FRM_EXIT;
            default:   row = FRM_POLL;
        endcase
        return row;
    endfunction

    function automatic logic [3:0] frame_len(logic [1:0] row);
        return (row == FRM_ENTER) ? 4'd5 : 4'd9;
    endfunction

    function automatic logic [7:0] frame_byte(logic [1:0] row, logic [3:0] pos);
        logic [7:0] b;
        b = 8'h00;
        unique case (pos)
            4'd0: b = 8'h01;
            4'd1:
            begin
                unique case (row)
                    FRM_ENTER:  b = 8'h43;
                    FRM_ANALOG: b = 8'h44;
                    FRM_EXIT:   b = 8'h43;
                    default:    b = 8'h42;
                endcase
            end
            4'd3: b = (row == FRM_ENTER || row == FRM_ANALOG) ? 8'h01 : 8'h00;
            4'd4:
            begin
                if (row == FRM_ANALOG)
                begin
                    b = 8'h03;
                end
                else if (row == FRM_EXIT)
                begin
                    b = 8'h5A;
                end
            end
            4'd5, 4'd6, 4'd7, 4'd8: b = (row == FRM_EXIT) ? 8'h5A : 8'h00;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> sv/gamepad_poll_sequencer.sv
// Gamepad poll sequencer.
// cmd channel: one transaction per command (configure, poll) or per byte
// exchanged on the serial link; rx_byte is the byte received for the byte
// last sent. res channel: exactly one result transaction per cmd
// transaction, giving the next byte to send, select and frame end, and the
// stored button, stick, id and status values.
// cfg channel: writes retry_limit (always ready); write it only while idle.
// The result is held in the output register and appears in the cycle after
// the cmd transaction. Throughput: one cmd transaction per cycle while the
// receiver takes each result; the state update is combinational.
// When the receiver stalls, cmd_ready stays high only if the held result is
// taken in the same cycle; otherwise cmd waits until res is accepted.
// Reset: sequencer idle, no buttons held, sticks and id zero, status idle,
// retry_limit 10, no result pending.
module gamepad_poll_sequencer
    import gps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  gps_cmd_t cmd,
    output logic     res_valid,
    input  logic     res_ready,
    output gps_res_t res,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic [3:0] cfg_retry_limit
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  pos_reg, pos_next;
    logic [3:0]  attempt_reg, attempt_next;
    logic [15:0] raw_reg, raw_next;
    logic [15:0] prev_reg, prev_next;
    logic [7:0]  stick_reg [4];
    logic [7:0]  stick_next [4];
    logic [7:0]  id_reg, id_next;
    logic [1:0]  link_reg, link_next;
    logic [3:0]  limit_reg;
    logic        res_valid_reg;
    gps_res_t    res_reg, res_next;
    logic        fend;
    logic        accept;

    logic [1:0]  row;
    logic [3:0]  pos_inc;
    logic [3:0]  attempt_inc;
    logic [3:0]  limit_eff;
    logic        running;

    assign cmd_ready = !res_valid_reg || res_ready;
    assign accept    = cmd_valid && cmd_ready;
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        attempt_next = attempt_reg;
        raw_next     = raw_reg;
        prev_next    = prev_reg;
        stick_next   = stick_reg;
        id_next      = id_reg;
        link_next    = link_reg;
        fend         = 1'b0;
        running      = (phase_reg != PH_IDLE);
        row          = frame_row(phase_reg);
        pos_inc      = pos_reg + 4'd1;
        attempt_inc  = (attempt_reg < ATTEMPT_MAX) ? attempt_reg + 4'd1 : attempt_reg;
        limit_eff    = (limit_reg == 4'd0) ? 4'd1 : limit_reg;

        if (!running)
        begin
            phase_next = PH_IDLE;
            pos_next   = 4'd0;
        end

        if (cmd.action == ACT_CONFIGURE)
        begin
            attempt_next = 4'd0;
            phase_next   = PH_ENTER;
            pos_next     = 4'd0;
        end
        else if (cmd.action == ACT_POLL)
        begin
            phase_next = PH_POLL_ONLY;
            pos_next   = 4'd0;
            prev_next  = raw_reg;
        end
        else if (cmd.action == ACT_BYTE && running)
        begin
            if (row == FRM_POLL)
            begin
                unique case (pos_reg)
                    4'd1: id_next = cmd.rx_byte;
                    4'd3: raw_next[7:0] = cmd.rx_byte;
                    4'd4: raw_next[15:8] = cmd.rx_byte;
                    4'd5: stick_next[0] = cmd.rx_byte;
                    4'd6: stick_next[1] = cmd.rx_byte;
                    4'd7: stick_next[2] = cmd.rx_byte;
                    4'd8: stick_next[3] = cmd.rx_byte;
                    default: ;
                endcase
            end
            pos_next = pos_inc;
            if (pos_inc >= frame_len(row))
            begin
                fend     = 1'b1;
                pos_next = 4'd0;
                unique case (phase_reg)
                    PH_ENTER:  phase_next = PH_ANALOG;
                    PH_ANALOG: phase_next = PH_EXIT;
                    PH_EXIT:
                    begin
                        phase_next = PH_POLL_CFG;
                        prev_next  = raw_next;
                    end
                    PH_POLL_CFG:
                    begin
                        attempt_next = attempt_inc;
                        if ((id_next & ID_MASK) == ID_ANALOG)
                        begin
                            link_next  = STAT_CONFIGURED;
                            phase_next = PH_IDLE;
                        end
                        else if (attempt_inc >= limit_eff)
                        begin
                            link_next  = STAT_FAILED;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_ENTER;
                        end
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
        end
    end

    // result
    always_comb
    begin
        logic [15:0] changed;
        changed                = raw_next ^ prev_next;
        res_next.select_active = (phase_next != PH_IDLE);
        res_next.tx_byte       = res_next.select_active
                                 ? frame_byte(frame_row(phase_next), pos_next) : 8'h00;
        res_next.frame_end      = fend;
        res_next.buttons_held   = ~raw_next;
        res_next.newly_pressed  = changed & ~raw_next;
        res_next.newly_released = changed & raw_next;
        res_next.right_x        = stick_next[0];
        res_next.right_y        = stick_next[1];
        res_next.left_x         = stick_next[2];
        res_next.left_y         = stick_next[3];
        res_next.device_id      = id_next;
        res_next.status         = res_next.select_active ? STAT_BUSY : link_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            pos_reg       <= 4'd0;
            attempt_reg   <= 4'd0;
            raw_reg       <= 16'hFFFF;
            prev_reg      <= 16'hFFFF;
            stick_reg     <= '{default: 8'h00};
            id_reg        <= 8'h00;
            link_reg      <= STAT_IDLE;
            limit_reg     <= RETRY_LIMIT_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                limit_reg <= cfg_retry_limit;
            end
            if (accept)
            begin
                phase_reg     <= phase_next;
                pos_reg       <= pos_next;
                attempt_reg   <= attempt_next;
                raw_reg       <= raw_next;
                prev_reg      <= prev_next;
                stick_reg     <= stick_next;
                id_reg        <= id_next;
                link_reg      <= link_next;
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import gps_pkg::*;

    localparam logic [1:0] ACT_NOP = 2'd3;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int NUM_PHASES = 7;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int LONG_HOLD_AFTER = 600;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [1:0] act;
        logic [7:0] rx;
        logic       typed;
        logic [7:0] tx;
        logic       sel;
        logic       fend;
        logic [1:0] st;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cmd_valid;
    logic       cmd_ready;
    gps_cmd_t   cmd;
    logic       res_valid;
    logic       res_ready;
    gps_res_t   res;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [3:0] cfg_retry_limit;

    gamepad_poll_sequencer DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .cmd             (cmd),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_retry_limit (cfg_retry_limit)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    int unsigned cycle_cnt = 0;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("gamepad_poll_sequencer regression: fail");
            $finish;
        end
    end

    // sequencer shadow state
    phase_t      ph = PH_IDLE;
    logic [3:0]  bpos = 4'd0;
    logic [3:0]  attempts = 4'd0;
    logic [3:0]  lim = RETRY_LIMIT_RESET;
    logic [15:0] raw_btn = 16'hFFFF;
    logic [15:0] prev_btn = 16'hFFFF;
    logic [7:0]  stick_b [4] = '{default: 8'h00};
    logic [7:0]  id_b = 8'h00;
    logic [1:0]  link = STAT_IDLE;

    logic [7:0] frame_tbl [4][9] = '{
        '{8'h01, 8'h43, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h01, 8'h44, 8'h00, 8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h01, 8'h43, 8'h00, 8'h00, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A},
        '{8'h01, 8'h42, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    logic [3:0] frame_size [4] = '{4'd5, 4'd9, 4'd9, 4'd9};

    gps_res_t pending_res [$];
    int unsigned errors = 0;
    int unsigned results_seen = 0;
    int unsigned send_gap_max = 18;
    int unsigned recv_gap_max = 18;
    bit long_hold_done = 1'b0;

    function automatic logic [1:0] row_of(phase_t p);
        logic [1:0] r;
        case (p)
            PH_ENTER:  r = FRM_ENTER;
            PH_ANALOG: r = FRM_ANALOG;
            PH_EXIT:   r = FRM_EXIT;
            default:   r = FRM_POLL;
        endcase
        return r;
    endfunction

    function automatic void open_frame(phase_t p);
        ph = p;
        bpos = 4'd0;
        if (p == PH_POLL_CFG || p == PH_POLL_ONLY)
            prev_btn = raw_btn;
    endfunction

    function automatic void close_frame();
        logic [3:0] eff;
        case (ph)
            PH_ENTER:  open_frame(PH_ANALOG);
            PH_ANALOG: open_frame(PH_EXIT);
            PH_EXIT:   open_frame(PH_POLL_CFG);
            PH_POLL_CFG:
            begin
                if (attempts < ATTEMPT_MAX)
                    attempts = attempts + 4'd1;
                eff = (lim == 4'd0) ? 4'd1 : lim;
                if ((id_b & ID_MASK) == ID_ANALOG)
                begin
                    link = STAT_CONFIGURED;
                    ph = PH_IDLE;
                    bpos = 4'd0;
                end
                else if (attempts >= eff)
                begin
                    link = STAT_FAILED;
                    ph = PH_IDLE;
                    bpos = 4'd0;
                end
                else
                begin
                    open_frame(PH_ENTER);
                end
            end
            default:
            begin
                ph = PH_IDLE;
                bpos = 4'd0;
            end
        endcase
    endfunction

    // advance the shadow sequencer by one cmd transaction, return the result
    function automatic gps_res_t sequence_step(gps_cmd_t c);
        gps_res_t    r;
        logic        running;
        logic [1:0]  row;
        logic [15:0] chg;
        r = '0;
        running = (ph != PH_IDLE);
        if (c.action == ACT_CONFIGURE)
        begin
            attempts = 4'd0;
            open_frame(PH_ENTER);
        end
        else if (c.action == ACT_POLL)
        begin
            open_frame(PH_POLL_ONLY);
        end
        else if (c.action == ACT_BYTE && running)
        begin
            row = row_of(ph);
            if (row == FRM_POLL)
            begin
                case (bpos)
                    4'd1: id_b = c.rx_byte;
                    4'd3: raw_btn[7:0] = c.rx_byte;
                    4'd4: raw_btn[15:8] = c.rx_byte;
                    4'd5, 4'd6, 4'd7, 4'd8: stick_b[bpos - 4'd5] = c.rx_byte;
                    default: ;
                endcase
            end
            bpos = bpos + 4'd1;
            if (bpos >= frame_size[row])
            begin
                r.frame_end = 1'b1;
                close_frame();
            end
        end
        if (ph != PH_IDLE)
        begin
            r.select_active = 1'b1;
            r.tx_byte = (bpos < 4'd9) ? frame_tbl[row_of(ph)][bpos] : 8'h00;
        end
        chg = raw_btn ^ prev_btn;
        r.buttons_held = ~raw_btn;
        r.newly_pressed = chg & ~raw_btn;
        r.newly_released = chg & raw_btn;
        r.right_x = stick_b[0];
        r.right_y = stick_b[1];
        r.left_x = stick_b[2];
        r.left_y = stick_b[3];
        r.device_id = id_b;
        r.status = (ph != PH_IDLE) ? STAT_BUSY : link;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task automatic cmp_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // one cmd transaction; called and returns at a falling edge
    task automatic send_cmd(input dir_row_t row);
        int unsigned gap;
        gps_cmd_t    c;
        gps_res_t    want;
        gap = $urandom_range(send_gap_max, 0);
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        c.action = row.act;
        c.rx_byte = row.rx;
        cmd <= c;
        cmd_valid <= 1'b1;
        do @(posedge clk); while (!cmd_ready);
        want = sequence_step(c);
        if (row.typed)
        begin
            want.tx_byte = row.tx;
            want.select_active = row.sel;
            want.frame_end = row.fend;
            want.status = row.st;
        end
        pending_res.push_back(want);
        @(negedge clk);
    endtask

    task automatic write_retry_limit(input logic [3:0] v);
        cfg_retry_limit <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        lim = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_res.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // result receiver
    initial
    begin
        int unsigned hold;
        gps_res_t    want;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            hold = $urandom_range(recv_gap_max, 0);
            if (!long_hold_done && results_seen >= LONG_HOLD_AFTER)
            begin
                // sender keeps offering, so the result register fills and cmd stalls
                hold = LONG_HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (hold != 0)
            begin
                res_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
            results_seen++;
            if (pending_res.size() == 0)
            begin
                report_mismatch("result transaction with nothing pending");
            end
            else
            begin
                want = pending_res.pop_front();
                cmp_field("tx_byte", 16'(res.tx_byte), 16'(want.tx_byte));
                cmp_field("select_active", 16'(res.select_active),
                          16'(want.select_active));
                cmp_field("frame_end", 16'(res.frame_end), 16'(want.frame_end));
                cmp_field("buttons_held", res.buttons_held, want.buttons_held);
                cmp_field("newly_pressed", res.newly_pressed, want.newly_pressed);
                cmp_field("newly_released", res.newly_released, want.newly_released);
                cmp_field("right_x", 16'(res.right_x), 16'(want.right_x));
                cmp_field("right_y", 16'(res.right_y), 16'(want.right_y));
                cmp_field("left_x", 16'(res.left_x), 16'(want.left_x));
                cmp_field("left_y", 16'(res.left_y), 16'(want.left_y));
                cmp_field("device_id", 16'(res.device_id), 16'(want.device_id));
                cmp_field("status", 16'(res.status), 16'(want.status));
            end
            @(negedge clk);
        end
    end

    dir_row_t dir_rows [24] = '{
        // idle: stray byte and unused action are ignored
        '{ACT_BYTE,      8'hFF, 1'b1, 8'h00, 1'b0, 1'b0, STAT_IDLE},
        '{ACT_NOP,       8'h00, 1'b1, 8'h00, 1'b0, 1'b0, STAT_IDLE},
        // poll frame alone
        '{ACT_POLL,      8'h00, 1'b1, 8'h01, 1'b1, 1'b0, STAT_BUSY},
        '{ACT_BYTE,      8'hFF, 1'b1, 8'h42, 1'b1, 1'b0, STAT_BUSY},
        '{ACT_BYTE,      8'h73, 1'b1, 8'h00, 1'b1, 1'b0, STAT_BUSY},
        '{ACT_BYTE,      8'h5A, 1'b0, 8'h00, 1'b0, 1'b0, STAT_IDLE},
        '{ACT_BYTE,      8'h00, 1'b0, 8'h00, 1'b0, 1'b0, STAT_IDLE},
        '{ACT_NOP,       8'h55, 1'b0, 8'h00, 1'b0, 1'b0, STAT_IDLE},
        '{ACT_BYTE,      8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, STAT_IDLE},
        '{ACT_BYTE,      8'h00, 1'b0, 8'h00, 1'b0, 1'b0, STAT_IDLE},
        '{ACT_BYTE,      8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, STAT_IDLE},
        '{ACT_BYTE,      8'h80, 1'b0, 8'h00, 1'b0, 1'b0, STAT_IDLE},
        '{ACT_BYTE,      8'h7F, 1'b1, 8'h00, 1'b0, 1'b1, STAT_IDLE},
        // second poll, then commands that cut frames short
        '{ACT_POLL,      8'hFF, 1'b1, 8'h01, 1'b1, 1'b0, STAT_BUSY},
        '{ACT_BYTE,      8'h00, 1'b0, 8'h00, 1'b0, 1'b0, STAT_IDLE},
        '{ACT_BYTE,      8'h12, 1'b0, 8'h00, 1'b0, 1'b0, STAT_IDLE},
        '{ACT_BYTE,      8'h00, 1'b0, 8'h00, 1'b0, 1'b0, STAT_IDLE},
        '{ACT_BYTE,      8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, STAT_IDLE},
        '{ACT_BYTE,      8'h00, 1'b0, 8'h00, 1'b0, 1'b0, STAT_IDLE},
        '{ACT_CONFIGURE, 8'h00, 1'b1, 8'h01, 1'b1, 1'b0, STAT_BUSY},
        '{ACT_BYTE,      8'h00, 1'b1, 8'h43, 1'b1, 1'b0, STAT_BUSY},
        '{ACT_BYTE,      8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, STAT_IDLE},
        '{ACT_POLL,      8'h00, 1'b1, 8'h01, 1'b1, 1'b0, STAT_BUSY},
        '{ACT_CONFIGURE, 8'hAA, 1'b1, 8'h01, 1'b1, 1'b0, STAT_BUSY}
    };

    logic [3:0] phase_limits [NUM_PHASES] =
        '{RETRY_LIMIT_RESET, 4'd1, 4'd0, 4'd15, 4'd2, 4'd15, 4'd7};

    initial
    begin
        dir_row_t    row;
        int unsigned counted;
        int unsigned good_pct;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        res_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_retry_limit = 4'd0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_cmd(dir_rows[i]);

        good_pct = 50;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p != 0)
            begin
                if (p == NUM_PHASES - 1)
                    write_retry_limit(4'($urandom_range(15, 1)));
                else
                    write_retry_limit(phase_limits[p]);
            end
            send_gap_max = (p % 3 == 1) ? 0 : 18;
            recv_gap_max = (p % 2 == 1) ? 0 : 18;
            counted = 0;
            while (counted < ITEMS_PER_PHASE || ph != PH_IDLE)
            begin
                row = '0;
                row.rx = 8'($urandom);
                if (counted < ITEMS_PER_PHASE && $urandom_range(99, 0) < 8)
                begin
                    row.act = 2'($urandom_range(3, 0));
                end
                else if (ph == PH_IDLE)
                begin
                    row.act = ($urandom_range(99, 0) < 60) ? ACT_CONFIGURE : ACT_POLL;
                end
                else
                begin
                    row.act = ACT_BYTE;
                    // id byte of the poll inside a configure decides accept or retry
                    if (row_of(ph) == FRM_POLL && bpos == 4'd1
                        && $urandom_range(99, 0) < good_pct)
                        row.rx = {4'h7, 4'($urandom)};
                end
                if (row.act == ACT_CONFIGURE)
                begin
                    case ($urandom_range(2, 0))
                        0:       good_pct = 0;
                        1:       good_pct = 30;
                        default: good_pct = 70;
                    endcase
                end
                if (!(row.act == ACT_NOP || (row.act == ACT_BYTE && ph == PH_IDLE)))
                    counted++;
                send_cmd(row);
            end
            cmd_valid <= 1'b0;
            drain();
        end

        if (errors == 0)
            $display("gamepad_poll_sequencer regression: pass");
        else
            $display("gamepad_poll_sequencer regression: fail");
        $finish;
    end

endmodule

>>> gamepad_poll_sequencer.f
sv/gps_pkg.sv
sv/gamepad_poll_sequencer.sv
tb/tb.sv
